FILE: src/ir2d_pkg.sv
// Package for the integer-to-radix digit converter.
// Holds radix limits, digit and character types and the digit-to-ASCII map.
// No dependencies.
package ir2d_pkg;

  typedef logic [4:0] radix_t;
  typedef logic [3:0] digit_t;
  typedef logic [6:0] char_t;

  localparam radix_t RADIX_RESET = 5'd10;
  localparam radix_t RADIX_MIN   = 5'd2;
  localparam radix_t RADIX_MAX   = 5'd16;

  // Quotient bits retired by the divider in one cycle
  localparam int unsigned STEP_BITS = 8;

  localparam char_t CHAR_ZERO  = 7'h30;  // '0'
  localparam char_t CHAR_A_OFS = 7'h57;  // 'a' minus ten
  localparam digit_t DIGIT_TEN = 4'd10;

  // Divider status toward the back end
  typedef struct packed {
    logic   done;
    digit_t rem;
  } div_stat_t;

  // Map one digit to its lower-case ASCII character
  function automatic char_t ascii_of(digit_t d);
    char_t c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + {3'b000, d};
    end else begin
      c = CHAR_A_OFS + {3'b000, d};
    end
    return c;
  endfunction

endpackage

FILE: src/ir2d_front.sv
// Front end: radix register, input acceptance and radix check.
// Pushes valid jobs into the job queue and drops items with a bad radix.
// Depends on ir2d_pkg.
module ir2d_front #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  ir2d_pkg::radix_t      cfg_data_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output logic [VALUE_BITS-1:0] q_value_o,
  output ir2d_pkg::radix_t      q_radix_o
);

  ir2d_pkg::radix_t radix_q;
  logic             accept;
  logic             radix_ok;

  // Take a config beat whenever offered
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= ir2d_pkg::RADIX_RESET;
    end else if (cfg_valid_i) begin
      radix_q <= cfg_data_i;
    end
  end

  // Stall only while the queue is full
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign radix_ok   = (radix_q >= ir2d_pkg::RADIX_MIN) && (radix_q <= ir2d_pkg::RADIX_MAX);

  // Forward good jobs, drop the rest
  assign q_push_o  = accept && radix_ok;
  assign q_value_o = value_i;
  assign q_radix_o = radix_q;

endmodule

FILE: src/ir2d_fifo.sv
// Two-entry job queue between front and back ends.
// Generic width; no package dependency.
module ir2d_fifo #(
  parameter int unsigned WIDTH = 36
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

FILE: src/ir2d_div.sv
// Iterative divider by a small radix: STEP_BITS quotient bits per cycle.
// Restoring long division with a 4-bit running remainder. Depends on ir2d_pkg.
module ir2d_div #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  ir2d_pkg::radix_t      radix_i,
  output ir2d_pkg::div_stat_t   stat_o,
  output logic [VALUE_BITS-1:0] quot_o
);

  localparam int unsigned STEP    = ir2d_pkg::STEP_BITS;
  localparam int unsigned DIV_CYC = (VALUE_BITS + STEP - 1) / STEP;
  localparam int unsigned PAD     = DIV_CYC * STEP;
  localparam int unsigned CCW     = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

  logic [PAD-1:0]          dq_q, dq_d;
  ir2d_pkg::digit_t        rem_q, rem_d;
  ir2d_pkg::radix_t        radix_q;
  logic [CCW-1:0]          cyc_q;
  logic                    busy_q;
  logic                    done_q;

  // Run STEP shift-compare-subtract steps
  always_comb begin
    logic [PAD-1:0]   d;
    ir2d_pkg::digit_t r;
    logic [4:0]       t;
    d = dq_q;
    r = rem_q;
    for (int i = 0; i < STEP; i++) begin
      t = {r, d[PAD-1]};
      d = {d[PAD-2:0], 1'b0};
      if (t >= radix_q) begin
        t    = t - radix_q;
        d[0] = 1'b1;
      end
      r = t[3:0];
    end
    dq_d  = d;
    rem_d = r;
  end

  // Load operands or advance the division
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q    <= PAD'(dividend_i);
      rem_q   <= '0;
      radix_q <= radix_i;
    end else if (busy_q) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cyc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cyc_q  <= '0;
      end else if (busy_q) begin
        if (cyc_q == CCW'(DIV_CYC - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cyc_q <= cyc_q + 1'b1;
        end
      end
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.rem  = rem_q;
  assign quot_o      = dq_q[VALUE_BITS-1:0];

endmodule

FILE: src/ir2d_back.sv
// Back end: drives the divider, stacks digits, pops them out MSD first.
// Holds the digit stack memory and the output register. Depends on ir2d_pkg.
module ir2d_back #(
  parameter int unsigned VALUE_BITS = 31,
  parameter int unsigned MAX_DIGITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  input  logic [VALUE_BITS-1:0] job_value_i,
  input  ir2d_pkg::radix_t      job_radix_i,
  output logic                  job_pop_o,
  output logic                  div_start_o,
  output logic [VALUE_BITS-1:0] div_dividend_o,
  output ir2d_pkg::radix_t      div_radix_o,
  input  ir2d_pkg::div_stat_t   div_stat_i,
  input  logic [VALUE_BITS-1:0] div_quot_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ir2d_pkg::char_t       digit_char_o,
  output logic                  last_char_o
);

  localparam int unsigned AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  ir2d_pkg::digit_t stack_q [MAX_DIGITS];
  ir2d_pkg::digit_t rd_q;
  logic [1:0]       state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d, cnt_dec;
  ir2d_pkg::radix_t radix_q;
  logic             out_v_q, out_v_d;
  logic             last_q;
  logic             push;
  logic             issue;
  logic             quot_zero;

  assign cnt_dec   = cnt_q - 1'b1;
  assign quot_zero = (div_quot_i == '0);
  assign push      = (state_q == ST_DIV) && div_stat_i.done && (cnt_q < CW'(MAX_DIGITS));
  assign issue     = (state_q == ST_EMIT) && (cnt_q != '0) && (!out_v_q || !out_stall_i);

  // Start from a new job, or restart on the quotient
  assign job_pop_o      = (state_q == ST_IDLE) && job_valid_i;
  assign div_start_o    = job_pop_o ||
                          ((state_q == ST_DIV) && div_stat_i.done && !quot_zero);
  assign div_dividend_o = job_pop_o ? job_value_i : div_quot_i;
  assign div_radix_o    = job_pop_o ? job_radix_i : radix_q;

  // Sequence one job
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        if (push) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (div_stat_i.done && quot_zero) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (issue) begin
          cnt_d = cnt_dec;
          if (cnt_q == CW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the output beat until taken
  always_comb begin
    if (issue) begin
      out_v_d = 1'b1;
    end else if (!out_stall_i) begin
      out_v_d = 1'b0;
    end else begin
      out_v_d = out_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      radix_q <= job_radix_i;
    end
  end

  // Push one remainder onto the stack
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_q[cnt_q[AW-1:0]] <= div_stat_i.rem;
    end
  end

  // Pop the top digit into the output register
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_q   <= stack_q[cnt_dec[AW-1:0]];
      last_q <= (cnt_q == CW'(1));
    end
  end

  assign out_valid_o  = out_v_q;
  assign digit_char_o = ir2d_pkg::ascii_of(rd_q);
  assign last_char_o  = last_q;

endmodule

FILE: src/integer_to_radix_digits_core.sv
// Top level of the integer-to-radix digit converter.
// Instantiates ir2d_front, ir2d_fifo, ir2d_div and ir2d_back; uses ir2d_pkg.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+----------------------------
//   in      | input     | in_valid_i/in_stall_o | value_i
//   cfg     | input     | cfg_valid_i/ready_o   | cfg_data_i (radix)
//   out     | output    | out_valid_o/stall_i   | digit_char_o, last_char_o
//
// Each digit takes a pass through the single divider, which retires 8 quotient
// bits a cycle; the characters are then popped from the stack in turn.
// Reset sets the radix to 10 and empties the queue; the stack needs no clearing.
// A two-entry queue lets the front keep accepting while the back works or the
// output is stalled. Items seen with a radix outside 2..16 produce no beats.
module integer_to_radix_digits_core #(
  parameter int unsigned VALUE_BITS = 31,
  parameter int unsigned MAX_DIGITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [4:0]            cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [6:0]            digit_char_o,
  output logic                  last_char_o
);

  localparam int unsigned QW = VALUE_BITS + 5;

  logic                  q_full, q_push, q_valid, q_pop;
  logic [VALUE_BITS-1:0] q_value;
  ir2d_pkg::radix_t      q_radix;
  logic [QW-1:0]         q_rd_data;
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend, div_quot;
  ir2d_pkg::radix_t      div_radix;
  ir2d_pkg::div_stat_t   div_stat;

  ir2d_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_value_o   (q_value),
    .q_radix_o   (q_radix)
  );

  ir2d_fifo #(.WIDTH(QW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({q_radix, q_value}),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_rd_data)
  );

  ir2d_div #(.VALUE_BITS(VALUE_BITS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .radix_i    (div_radix),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  ir2d_back #(.VALUE_BITS(VALUE_BITS), .MAX_DIGITS(MAX_DIGITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (q_valid),
    .job_value_i    (q_rd_data[VALUE_BITS-1:0]),
    .job_radix_i    (q_rd_data[QW-1:VALUE_BITS]),
    .job_pop_o      (q_pop),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_radix_o    (div_radix),
    .div_stat_i     (div_stat),
    .div_quot_i     (div_quot),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .digit_char_o   (digit_char_o),
    .last_char_o    (last_char_o)
  );

  // Every emitted character is a lower-case hex digit
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((digit_char_o >= 7'h30 && digit_char_o <= 7'h39) ||
                     (digit_char_o >= 7'h61 && digit_char_o <= 7'h66)))
    else $error("character out of digit range");

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("job queue overflow");

  // Outside a job pop, a new division starts only when the divider has a result
  a_start_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_start && !q_pop) |-> div_stat.done)
    else $error("divider restarted without a result");

endmodule

FILE: bench/ir2d_digit_checker.sv
`timescale 1ns / 1ps
// Checker for the integer-to-radix digit converter: tracks the radix register,
// predicts the character beats of each accepted value and compares them in order.
// Depends on ir2d_pkg for the radix and character types.
module ir2d_digit_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [30:0]       value_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  ir2d_pkg::radix_t  cfg_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  ir2d_pkg::char_t   digit_char_i,
  input  logic              last_char_i,
  output int                error_count_o,
  output int                pending_count_o
);

  localparam ir2d_pkg::char_t CH_ZERO    = 7'h30;  // '0'
  localparam ir2d_pkg::char_t CH_LOWER_A = 7'h61;  // 'a'

  typedef struct packed {
    ir2d_pkg::char_t ch;
    logic            last;
  } char_beat_t;

  // Characters still owed by the block, oldest first
  char_beat_t       expected_chars[$];
  ir2d_pkg::radix_t radix_q;

  function automatic ir2d_pkg::char_t char_of_digit(ir2d_pkg::digit_t d);
    if (d < ir2d_pkg::DIGIT_TEN) return CH_ZERO + ir2d_pkg::char_t'(d);
    return CH_LOWER_A + ir2d_pkg::char_t'(d - ir2d_pkg::DIGIT_TEN);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track_digits
    char_beat_t       want;
    ir2d_pkg::digit_t digits [32];
    int unsigned      rest;
    int               n;
    if (!rst_ni) begin
      radix_q       = ir2d_pkg::RADIX_RESET;
      error_count_o = 0;
      expected_chars.delete();
    end else begin
      // Compare one output beat with the oldest expected character
      if (out_valid_i && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          $error("digit_char: no beat expected, got %0h (last_char %0b)",
                 digit_char_i, last_char_i);
          error_count_o++;
        end else begin
          want = expected_chars.pop_front();
          if (digit_char_i !== want.ch) begin
            $error("digit_char: expected %0h, got %0h", want.ch, digit_char_i);
            error_count_o++;
          end
          if (last_char_i !== want.last) begin
            $error("last_char: expected %0b, got %0b", want.last, last_char_i);
            error_count_o++;
          end
        end
      end

      // Expand an accepted value into digits; out-of-range radix drops it
      if (in_valid_i && !in_stall_i && radix_q >= ir2d_pkg::RADIX_MIN &&
          radix_q <= ir2d_pkg::RADIX_MAX) begin
        rest = {1'b0, value_i};
        n    = 0;
        do begin
          digits[n] = ir2d_pkg::digit_t'(rest % radix_q);
          rest      = rest / radix_q;
          n++;
        end while (rest != 0);
        for (int i = n - 1; i >= 0; i--) begin
          want.ch   = char_of_digit(digits[i]);
          want.last = (i == 0);
          expected_chars.push_back(want);
        end
      end

      // Follow register writes; a value taken at the same edge used the old radix
      if (cfg_valid_i && cfg_ready_i) radix_q = cfg_data_i;
    end
    pending_count_o = expected_chars.size();
  end

endmodule

FILE: bench/integer_to_radix_digits_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for integer_to_radix_digits_core: drives values and radix writes,
// stalls the output side and gives the verdict. Uses ir2d_pkg and ir2d_digit_checker.
module integer_to_radix_digits_core_tb;

  localparam logic [30:0] VALUE_MAX  = 31'h7FFF_FFFF;
  localparam int SETTLE_CYCLES  = 800;
  localparam int DRAIN_LIMIT    = 100000;
  localparam int STRETCH_AFTER  = 60;
  localparam int STRETCH_CYCLES = 500;
  localparam int PHASE_ITEMS    = 45;
  localparam int RANDOM_PHASES  = 10;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic [30:0]      value     = '0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  ir2d_pkg::radix_t cfg_data  = '0;
  logic             out_valid;
  logic             out_hold  = 1'b0;
  ir2d_pkg::char_t  digit_char;
  logic             last_char;
  int               mismatches;
  int               outstanding;
  int               values_sent = 0;
  bit               in_quiet    = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  integer_to_radix_digits_core i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .value_i      (value),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_hold),
    .digit_char_o (digit_char),
    .last_char_o  (last_char)
  );

  ir2d_digit_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .value_i         (value),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_hold),
    .digit_char_i    (digit_char),
    .last_char_i     (last_char),
    .error_count_o   (mismatches),
    .pending_count_o (outstanding)
  );

  // Mix of zero, short, full-width, near-max and radix-power values
  function automatic logic [30:0] pick_value(input ir2d_pkg::radix_t r);
    longint unsigned p;
    int unsigned     base;
    int unsigned     k;
    base = (r >= ir2d_pkg::RADIX_MIN && r <= ir2d_pkg::RADIX_MAX) ? {27'd0, r} : 32'd10;
    unique case ($urandom_range(0, 5))
      0: return 31'd0;
      1: return 31'($urandom_range(1, 300));
      2: return 31'($urandom);
      3: begin
        p = 1;
        k = $urandom_range(1, 30);
        repeat (k) if (p * base <= VALUE_MAX) p = p * base;
        p = p + longint'($urandom_range(0, 2)) - 1;
        return 31'(p);
      end
      4: return 31'($urandom >> $urandom_range(1, 30));
      default: return VALUE_MAX - 31'($urandom_range(0, 3));
    endcase
  endfunction

  // Offer one value beat after a random gap and hold it until accepted
  task automatic send_value(input logic [30:0] v);
    int gap;
    if (values_sent % 20 == 0) in_quiet = ($urandom_range(0, 3) == 0);
    gap = in_quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (in_stall);
    values_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed character has come and the block settles
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_radix(input ir2d_pkg::radix_t r);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A radix outside 2..16 must swallow every value silently
  task automatic run_rejected_phase(input ir2d_pkg::radix_t r);
    write_radix(r);
    repeat (3) send_value(pick_value(r));
    finish_phase();
  endtask

  // Output side: random stalls, quiet stretches, one long hold-off
  initial begin : drain_side
    int gap;
    int beats;
    bit stretched;
    bit quiet;
    beats     = 0;
    stretched = 1'b0;
    quiet     = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (beats % 16 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (!stretched && values_sent >= STRETCH_AFTER) begin
        stretched = 1'b1;
        gap       = STRETCH_CYCLES;
      end else begin
        gap = quiet ? 0 : $urandom_range(0, 4);
      end
      if (gap != 0) begin
        out_hold <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_hold <= 1'b0;
      do @(posedge clk); while (!out_valid);
      beats++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    ir2d_pkg::radix_t phase_radix;
    int               drained;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Decimal at the reset radix: zero, one, digit rollovers, widest value
    send_value(31'd0);
    send_value(31'd1);
    send_value(31'd9);
    send_value(31'd10);
    send_value(31'd99);
    send_value(31'd100);
    send_value(31'd1_000_000_000);
    send_value(31'h4000_0000);
    send_value(VALUE_MAX);
    finish_phase();

    // Binary: longest digit strings and alternating bits
    write_radix(5'd2);
    send_value(31'd0);
    send_value(31'd1);
    send_value(31'd2);
    send_value(31'h5555_5555);
    send_value(31'h2AAA_AAAA);
    send_value(VALUE_MAX);
    finish_phase();

    // Hex: every letter digit and the top of the range
    write_radix(5'd16);
    send_value(31'd15);
    send_value(31'd16);
    send_value(31'h0ABC_DEF0);
    send_value(31'h1234_5678);
    send_value(31'd0);
    send_value(VALUE_MAX);
    finish_phase();

    // Out-of-range radix values, both field extremes among them
    run_rejected_phase(5'd0);
    run_rejected_phase(5'd1);
    run_rejected_phase(5'd17);
    run_rejected_phase(5'd31);

    // Random values over several radices, extremes first
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) phase_radix = ir2d_pkg::RADIX_MIN;
      else if (p == 1) phase_radix = ir2d_pkg::RADIX_MAX;
      else phase_radix = ir2d_pkg::radix_t'($urandom_range(ir2d_pkg::RADIX_MIN,
                                                             ir2d_pkg::RADIX_MAX));
      write_radix(phase_radix);
      repeat (PHASE_ITEMS) send_value(pick_value(phase_radix));
      finish_phase();
    end

    // Drain with a limit, then give the verdict
    drained = 0;
    while (outstanding != 0 && drained < DRAIN_LIMIT) begin
      @(negedge clk);
      drained++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (outstanding != 0) $error("%0d expected characters never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("integer_to_radix_digits_core_tb: done, clean");
    end else begin
      $display("integer_to_radix_digits_core_tb: done, errors");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run
  initial begin : watchdog
    #3_000_000;
    $display("integer_to_radix_digits_core_tb: done, errors");
    $finish;
  end

endmodule
